// ----- rtl/core/ptd_pkg.sv -----
// ptd_pkg: action, result-kind and register-index codes for the periodic task dispatcher,
// plus the command/status structs between controller and datapath.
// no dependencies
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned TASK_W   = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned NUM_IV   = 4;

  localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POLL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DONE  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DISPATCH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FINISHED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STARTED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_3 = 3'd4;

  typedef struct packed {
    logic              load;        // capture action and time of an accepted item
    logic              stamp;       // write the item time into every last-run entry
    logic              begin_poll;  // scan from task zero
    logic              begin_done;  // close running task, scan from the next one
    logic              advance;     // step scan index
    logic              commit;      // dispatch task at scan index
    logic              emit;        // load output registers
    logic [KIND_W-1:0] kind;
    logic              last;
  } ptd_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                running;
    logic                scan_end;
    logic                due;
  } ptd_status_t;

endpackage

// ----- rtl/core/ptd_ctrl.sv -----
// ptd_ctrl: sequencing state machine of the periodic task dispatcher
// depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ptd_pkg::ptd_status_t status_i,
  output ptd_pkg::ptd_cmd_t    cmd_o
);
  import ptd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DISP   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       from_done_q, from_done_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    from_done_d = from_done_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.action)
          ACT_START: begin
            cmd_o.stamp = 1'b1;
            cmd_o.emit  = 1'b1;
            cmd_o.kind  = KIND_STARTED;
            cmd_o.last  = 1'b1;
            state_d     = S_IDLE;
          end
          ACT_POLL: begin
            if (!status_i.running) begin
              cmd_o.begin_poll = 1'b1;
              from_done_d      = 1'b0;
              state_d          = S_SCAN;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KIND_IGNORED;
              cmd_o.last = 1'b1;
              state_d    = S_IDLE;
            end
          end
          ACT_DONE: begin
            if (status_i.running) begin
              cmd_o.begin_done = 1'b1;
              from_done_d      = 1'b1;
              state_d          = S_SCAN;
            end else begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KIND_IGNORED;
              cmd_o.last = 1'b1;
              state_d    = S_IDLE;
            end
          end
          default: begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_IGNORED;
            cmd_o.last = 1'b1;
            state_d    = S_IDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (status_i.scan_end) begin
          // pass over with no task due; a done item only reports the finish
          cmd_o.emit = 1'b1;
          cmd_o.kind = from_done_q ? KIND_FINISHED : KIND_NONE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end else if (status_i.due) begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.kind   = from_done_q ? KIND_FINISHED : KIND_DISPATCH;
          cmd_o.last   = !from_done_q;
          state_d      = from_done_q ? S_DISP : S_IDLE;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_DISP: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = KIND_DISPATCH;
        cmd_o.last = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      from_done_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      from_done_q <= from_done_d;
    end
  end

endmodule

// ----- rtl/core/ptd_datapath.sv -----
// ptd_datapath: configuration registers, last-run times, scan index, due compare
// and the result registers of the periodic task dispatcher; depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_datapath #(
  parameter int unsigned TASKS     = 4,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptd_pkg::FIELD_W-1:0]       cfg_wdata_i,
  input  logic [ptd_pkg::ACTION_W-1:0]      action_i,
  input  logic [ptd_pkg::FIELD_W-1:0]       now_i,
  input  ptd_pkg::ptd_cmd_t                 cmd_i,
  output ptd_pkg::ptd_status_t              status_o,
  output logic                              res_strobe_o,
  output logic [ptd_pkg::KIND_W-1:0]        kind_o,
  output logic [ptd_pkg::TASK_W-1:0]        task_res_o,
  output logic [ptd_pkg::FIELD_W-1:0]       time_taken_o,
  output logic                              last_o
);
  import ptd_pkg::*;

  localparam int unsigned TW    = TIME_BITS;
  localparam int unsigned CW    = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
  localparam int unsigned IDX_W = $clog2(TASKS + 1);
  localparam int unsigned TI_W  = (TASKS > 1) ? $clog2(TASKS) : 1;

  // configuration
  logic [COUNT_W-1:0] task_count_q;
  logic [FIELD_W-1:0] iv_q [NUM_IV];

  // task state
  logic [TW-1:0]    lrt_q [TASKS];
  logic             run_q;
  logic [TI_W-1:0]  run_task_q;
  logic [IDX_W-1:0] idx_q;

  // item and finish capture
  logic [ACTION_W-1:0] act_q;
  logic [TW-1:0]       now_q;
  logic [FIELD_W-1:0]  taken_q;
  logic [TI_W-1:0]     done_task_q;

  logic               strobe_q;
  logic [KIND_W-1:0]  kind_q;
  logic [TASK_W-1:0]  task_q;
  logic [FIELD_W-1:0] time_q;
  logic               last_q;

  logic [COUNT_W-1:0] count_sat;
  logic [TI_W-1:0]    ti;
  logic [1:0]         iv_sel;
  logic [TW-1:0]      elapsed;
  logic [TW-1:0]      run_elapsed;
  logic [TASK_W-1:0]  task_d;
  logic [FIELD_W-1:0] time_d;

  assign count_sat   = (task_count_q > COUNT_W'(TASKS)) ? COUNT_W'(TASKS) : task_count_q;
  assign ti          = TI_W'(idx_q);
  assign iv_sel      = 2'(idx_q);
  // entries beyond the task count are never read: scan_end masks them
  assign elapsed     = now_q - lrt_q[ti];
  assign run_elapsed = now_q - lrt_q[run_task_q];

  assign status_o.action   = act_q;
  assign status_o.running  = run_q;
  assign status_o.scan_end = !(COUNT_W'(idx_q) < count_sat);
  assign status_o.due      = (CW'(elapsed) >= CW'(iv_q[iv_sel]));

  always_comb begin
    case (cmd_i.kind)
      KIND_FINISHED: begin
        task_d = TASK_W'(done_task_q);
        time_d = taken_q;
      end
      KIND_DISPATCH: begin
        task_d = TASK_W'(idx_q);
        time_d = '0;
      end
      default: begin
        task_d = '0;
        time_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      for (int i = 0; i < NUM_IV; i++) iv_q[i] <= '0;
      for (int i = 0; i < TASKS; i++) lrt_q[i] <= '0;
      run_q      <= 1'b0;
      run_task_q <= '0;
      idx_q      <= '0;
      strobe_q   <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TASK_COUNT: task_count_q <= cfg_wdata_i[COUNT_W-1:0];
          CFG_INTERVAL_0: iv_q[0] <= cfg_wdata_i;
          CFG_INTERVAL_1: iv_q[1] <= cfg_wdata_i;
          CFG_INTERVAL_2: iv_q[2] <= cfg_wdata_i;
          CFG_INTERVAL_3: iv_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.stamp) begin
        for (int i = 0; i < TASKS; i++) lrt_q[i] <= now_q;
        run_q      <= 1'b0;
        run_task_q <= '0;
      end
      if (cmd_i.begin_poll) begin
        idx_q <= '0;
      end
      if (cmd_i.begin_done) begin
        idx_q      <= IDX_W'(run_task_q) + IDX_W'(1);
        run_q      <= 1'b0;
        run_task_q <= '0;
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.commit) begin
        lrt_q[ti]  <= now_q;
        run_q      <= 1'b1;
        run_task_q <= ti;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      now_q <= TW'(now_i);
    end
    if (cmd_i.begin_done) begin
      taken_q     <= FIELD_W'(run_elapsed);
      done_task_q <= run_task_q;
    end
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      task_q <= task_d;
      time_q <= time_d;
      last_q <= cmd_i.last;
    end
  end

  assign res_strobe_o = strobe_q;
  assign kind_o       = kind_q;
  assign task_res_o   = task_q;
  assign time_taken_o = time_q;
  assign last_o       = last_q;

endmodule

// ----- rtl/core/periodic_task_dispatcher.sv -----
// A start or ignored item shows its result once the item is decoded; a poll shows it once
// the compare unit, scanning one task entry after another, finds a due task or the end.
// A done item that dispatches again shows its second result in the cycle after the first.
// busy is high from the transfer until the last result is registered, and results
// cannot be stalled.
// Reset clears configuration, last-run times and the running flag.
`timescale 1ns / 1ps

module periodic_task_dispatcher #(
  parameter int unsigned TASKS     = 4,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptd_pkg::ACTION_W-1:0]  action_i,
  input  logic [ptd_pkg::FIELD_W-1:0]   now_i,
  input  logic                          cfg_we_i,
  input  logic [ptd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ptd_pkg::FIELD_W-1:0]   cfg_wdata_i,
  output logic                          res_strobe_o,
  output logic [ptd_pkg::KIND_W-1:0]    kind_o,
  output logic [ptd_pkg::TASK_W-1:0]    task_res_o,
  output logic [ptd_pkg::FIELD_W-1:0]   time_taken_o,
  output logic                          last_o
);
  import ptd_pkg::*;

  ptd_cmd_t    cmd;
  ptd_status_t status;

  ptd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ptd_datapath #(
    .TASKS     (TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .now_i        (now_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .res_strobe_o (res_strobe_o),
    .kind_o       (kind_o),
    .task_res_o   (task_res_o),
    .time_taken_o (time_taken_o),
    .last_o       (last_o)
  );

endmodule

// ----- rtl/core/ptd_checker.sv -----
// ptd_checker: port-level assertions for periodic_task_dispatcher, bound to the top level
// depends on ptd_pkg
`timescale 1ns / 1ps

module ptd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          res_strobe_o,
  input logic [ptd_pkg::KIND_W-1:0]    kind_o,
  input logic [ptd_pkg::FIELD_W-1:0]   time_taken_o,
  input logic                          last_o
);
  import ptd_pkg::*;

  // an accepted transfer raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // only a finished report can be followed by another result of the same item
  a_not_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_o) |-> (kind_o == KIND_FINISHED))
    else $error("non-final result is not a finished report");

  a_not_last_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !last_o) |=> (res_strobe_o && last_o && kind_o == KIND_DISPATCH))
    else $error("finished report not followed by dispatch");

  a_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && kind_o != KIND_FINISHED) |-> (time_taken_o == '0))
    else $error("time taken set on a result other than a finished report");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .kind_o       (kind_o),
  .time_taken_o (time_taken_o),
  .last_o       (last_o)
);
